// ----- rtl/rfu_pkg.sv -----
`default_nettype none
package rfu_pkg;
    localparam int WIN_BYTES  = 12;
    localparam int NAME_FIRST = 28;
    localparam int NAME_CHARS = 8;

    localparam logic [7:0] MAGIC_0   = 8'h52;
    localparam logic [7:0] MAGIC_1   = 8'h46;
    localparam logic [7:0] MAGIC_2   = 8'h55;
    localparam logic [7:0] MAGIC_3   = 8'h31;
    localparam logic [7:0] NAME_STOP = 8'hFF;

    localparam logic [6:0] SIZE_BEACON = 7'd36;
    localparam logic [6:0] SIZE_SHORT  = 7'd16;
    localparam logic [6:0] SIZE_LONG   = 7'd104;

    // completed-record request from front to back
    typedef struct packed {
        logic [2:0]  rtype;
        logic [31:0] header;
        logic        beacon;
        logic [63:0] name_raw;
    } rec_t;

    function automatic logic [6:0] size_of_type(input logic [31:0] t);
        logic [6:0] s;
        s = 7'd0;
        if (t == 32'd0) s = SIZE_BEACON;
        else if (t == 32'd1 || t == 32'd2 || t == 32'd4) s = SIZE_SHORT;
        else if (t == 32'd5 || t == 32'd6) s = SIZE_LONG;
        return s;
    endfunction

    function automatic logic [6:0] map_char(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'hBB && c <= 8'hD4) r = 7'(8'h41 + (c - 8'hBB));
        else if (c >= 8'hD5 && c <= 8'hEE) r = 7'(8'h61 + (c - 8'hD5));
        else if (c >= 8'hA1 && c <= 8'hAA) r = 7'(8'h30 + (c - 8'hA1));
        else if (c == 8'h00) r = 7'h20;
        else r = 7'h3F;
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/rfu1_record_deframer.sv -----
// rfu1_record_deframer: RFU1 record hunter on a byte stream.
// Results pass the front record register, the back queue, then registered outputs.
// Throughput: one byte per cycle while in_ready is high; the back queue decides it.
// A result waiting at the output stalls input only once the 2-entry queue holds one.
// Reset (rst_n, async low) clears counters, the pending record and the queue.
`default_nettype none
module rfu1_record_deframer
    import rfu_pkg::*;
#(
    parameter int STORE_BYTES = 256,
    parameter int MAX_CHUNK   = 64
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        chunk_start,
    input  wire logic [6:0]  chunk_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       record_type,
    output logic [31:0]      header_word,
    output logic [31:0]      beacons_seen,
    output logic             first_beacon,
    output logic [15:0]      device_id,
    output logic [55:0]      host_name,
    output logic [3:0]       name_length
);
    logic rec_valid;
    rec_t rec;
    logic q_ready;

    // queue empty: one record in flight plus one from this byte always fit
    assign in_ready = q_ready;

    rfu_front #(.STORE_BYTES(STORE_BYTES), .MAX_CHUNK(MAX_CHUNK)) u_front (
        .clk, .rst_n, .in_fire(in_valid && in_ready),
        .data_byte, .chunk_start, .chunk_length, .rec_valid, .rec
    );

    rfu_back u_back (
        .clk, .rst_n, .rec_valid, .rec, .q_ready, .out_valid, .out_ready,
        .record_type, .header_word, .beacons_seen, .first_beacon,
        .device_id, .host_name, .name_length
    );
endmodule
`default_nettype wire

// ----- rtl/rfu_front.sv -----
`default_nettype none
module rfu_front
    import rfu_pkg::*;
#(
    parameter int STORE_BYTES = 256,
    parameter int MAX_CHUNK   = 64
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_fire,
    input  wire logic [7:0] data_byte,
    input  wire logic       chunk_start,
    input  wire logic [6:0] chunk_length,
    output logic            rec_valid,
    output rec_t            rec
);
    localparam int CW = $clog2(STORE_BYTES + 129) + 1;

    logic [7:0]  win_reg [WIN_BYTES];
    logic [7:0]  nm_reg  [NAME_CHARS];
    logic [8:0]  cnt_reg;
    logic [6:0]  size_reg, left_reg;
    logic [31:0] hdr_reg;
    logic        latched_reg;

    logic [6:0]  len;
    logic        ovf;
    logic [8:0]  cnt0;
    logic [6:0]  size0, left0;
    logic [31:0] w4, w8;
    logic        magic;
    logic [6:0]  nsize;

    always_comb
    begin
        len = (32'(chunk_length) > MAX_CHUNK) ? 7'(MAX_CHUNK) : chunk_length;
        ovf = chunk_start && (CW'(cnt_reg) + CW'(len) > CW'(STORE_BYTES));
        cnt0  = ovf ? 9'd0 : cnt_reg;
        size0 = ovf ? 7'd0 : size_reg;
        left0 = ovf ? 7'd0 : left_reg;
    end

    // window bytes as they stand after this byte is written at cnt0
    logic [7:0] wv [WIN_BYTES];
    always_comb
    begin
        for (int i = 0; i < WIN_BYTES; i++)
            wv[i] = (cnt0 == 9'(i)) ? data_byte : win_reg[i];
        w4 = {wv[4], wv[5], wv[6], wv[7]};
        w8 = {wv[8], wv[9], wv[10], wv[11]};
        magic = wv[0] == MAGIC_0 && wv[1] == MAGIC_1 && wv[2] == MAGIC_2 && wv[3] == MAGIC_3;
        nsize = magic ? size_of_type(w4) : 7'd0;
    end

    logic        is_beacon;
    logic [6:0]  left_dec;
    logic [7:0]  nv [NAME_CHARS];
    logic        nwr;
    logic [2:0]  nidx;
    always_comb
    begin
        is_beacon = win_reg[7] == 8'd0;
        nwr = is_beacon && !latched_reg && cnt0 >= 9'(NAME_FIRST)
              && cnt0 < 9'(NAME_FIRST + NAME_CHARS);
        // name slot counts from the first name byte of the record
        nidx = 3'(cnt0 - 9'(NAME_FIRST));
        for (int i = 0; i < NAME_CHARS; i++)
            nv[i] = (nwr && nidx == 3'(i)) ? data_byte : nm_reg[i];
        left_dec = (left0 != 7'd0) ? left0 - 7'd1 : 7'd0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (size0 == 7'd0)
            begin
                if (cnt0 + 9'd1 >= 9'(WIN_BYTES) && nsize == 7'd0)
                    for (int i = 0; i < WIN_BYTES - 1; i++) win_reg[i] <= wv[i + 1];
                else
                    for (int i = 0; i < WIN_BYTES; i++) win_reg[i] <= wv[i];
            end
            else
                for (int i = 0; i < NAME_CHARS; i++) nm_reg[i] <= nv[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0; size_reg <= '0; left_reg <= '0; hdr_reg <= '0;
            latched_reg <= 1'b0; rec_valid <= 1'b0;
        end
        else
        begin
            rec_valid <= 1'b0;
            if (in_fire)
            begin
                size_reg <= size0; left_reg <= left0;
                if (size0 == 7'd0)
                begin
                    cnt_reg <= cnt0 + 9'd1;
                    if (cnt0 + 9'd1 >= 9'(WIN_BYTES))
                    begin
                        if (nsize == 7'd0) cnt_reg <= 9'(WIN_BYTES - 1);
                        else
                        begin
                            size_reg <= nsize; hdr_reg <= w8;
                            left_reg <= nsize - 7'(WIN_BYTES);
                            cnt_reg  <= 9'(WIN_BYTES);
                        end
                    end
                end
                else
                begin
                    cnt_reg <= cnt0 + 9'd1; left_reg <= left_dec;
                    if (left_dec == 7'd0)
                    begin
                        rec_valid <= 1'b1;
                        rec.rtype  <= win_reg[7][2:0];
                        rec.header <= hdr_reg;
                        rec.beacon <= is_beacon;
                        for (int i = 0; i < NAME_CHARS; i++)
                            rec.name_raw[8*i +: 8] <= nv[i];
                        if (is_beacon) latched_reg <= 1'b1;
                        size_reg <= '0; cnt_reg <= '0;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/rfu_back.sv -----
`default_nettype none
module rfu_back
    import rfu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rec_valid,
    input  rec_t             rec,
    output logic             q_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       record_type,
    output logic [31:0]      header_word,
    output logic [31:0]      beacons_seen,
    output logic             first_beacon,
    output logic [15:0]      device_id,
    output logic [55:0]      host_name,
    output logic [3:0]       name_length
);
    // two-entry queue of completed records
    rec_t       q_reg [2];
    logic [1:0] qn_reg;
    logic       rd_reg, wr_reg;
    logic       pop;

    logic [31:0] total_reg;
    logic        latched_reg;
    logic [15:0] id_reg;
    logic [55:0] nm_reg;
    logic [3:0]  nl_reg;

    assign q_ready = qn_reg == 2'd0;   // room for a record and a byte in flight
    assign pop = qn_reg != 2'd0 && (!out_valid || out_ready);

    rec_t h;
    logic [55:0] nm;
    logic [3:0]  nl;
    logic        stop;
    logic [7:0]  c;
    always_comb
    begin
        h = q_reg[rd_reg];
        nm = '0; nl = '0; stop = 1'b0;
        for (int k = 0; k < NAME_CHARS; k++)
        begin
            c = h.name_raw[8*((k & 4) | (3 - (k & 3))) +: 8];
            if (c == NAME_STOP) stop = 1'b1;
            if (!stop)
            begin
                nm[7*k +: 7] = map_char(c);
                nl = nl + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_valid) q_reg[wr_reg] <= rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qn_reg <= '0; rd_reg <= 1'b0; wr_reg <= 1'b0; out_valid <= 1'b0;
            total_reg <= '0; latched_reg <= 1'b0;
            id_reg <= '0; nm_reg <= '0; nl_reg <= '0;
        end
        else
        begin
            qn_reg <= qn_reg + 2'(rec_valid) - 2'(pop);
            if (rec_valid) wr_reg <= ~wr_reg;
            if (out_valid && out_ready) out_valid <= 1'b0;
            if (pop)
            begin
                rd_reg <= ~rd_reg;
                out_valid <= 1'b1;
                record_type <= h.rtype;
                header_word <= h.header;
                first_beacon <= h.beacon && !latched_reg;
                if (h.beacon)
                begin
                    total_reg <= total_reg + 32'd1;
                    beacons_seen <= total_reg + 32'd1;
                end
                else beacons_seen <= total_reg;
                if (h.beacon && !latched_reg)
                begin
                    latched_reg <= 1'b1; id_reg <= h.header[15:0];
                    nm_reg <= nm; nl_reg <= nl;
                    device_id <= h.header[15:0]; host_name <= nm; name_length <= nl;
                end
                else
                begin
                    device_id <= id_reg; host_name <= nm_reg; name_length <= nl_reg;
                end
            end
        end
    end
endmodule
`default_nettype wire
